### rtl/mlpf_pkg.sv
// ----------------------------------------------------------------------------
// mlpf_pkg: shared types, codes and table helpers for the perceptron block
// Holds field widths, item and command codes, the command record that the
// front part hands to the back part, and the sigmoid table generator.
// ----------------------------------------------------------------------------
package mlpf_pkg;

	// Field widths.
	localparam int KIND_W   = 2;
	localparam int IDX_W    = 8;
	localparam int VAL_W    = 24;
	localparam int PRED_W   = 17;
	localparam int CNT_W    = 5;
	localparam int ACC_W    = 48;
	localparam int CFG_AW   = 1;

	// Defaults of the top-level parameters.
	localparam int DEF_MAX_INPUTS  = 16;
	localparam int DEF_MAX_HIDDEN  = 16;
	localparam int DEF_TABLE_DEPTH = 1024;

	// Register reset values.
	localparam logic [CNT_W-1:0] INPUTS_RESET = 5'd11;
	localparam logic [CNT_W-1:0] HIDDEN_RESET = 5'd16;

	// Register indexes on the configuration port.
	localparam logic [CFG_AW-1:0] REG_INPUTS = 1'b0;
	localparam logic [CFG_AW-1:0] REG_HIDDEN = 1'b1;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_HW_WR   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_OW_WR   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FEATURE = 2'd2;

	// Command operations.
	localparam logic [1:0] OP_HW_WR   = 2'd0;
	localparam logic [1:0] OP_OW_WR   = 2'd1;
	localparam logic [1:0] OP_FEATURE = 2'd2;

	// Command queue depth.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	// One classified command.
	typedef struct packed {
		logic [1:0]              op;
		logic                    last;
		logic [CNT_W-1:0]        nh;
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	// Restoring unsigned division, used only while building constants.
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] d);
		logic [63:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], a[b]};
			if (r >= d) begin
				r = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-f) for f in [0,1] in Q2.30, alternating Taylor series of 21 terms.
	function automatic logic [63:0] exp_neg(input logic [63:0] f);
		longint      sum;
		logic [63:0] term;
		sum  = longint'(ONE_Q30);
		term = ONE_Q30;
		for (int k = 1; k <= 20; k++) begin
			term = udiv64((term * f) >> 30, 64'(k));
			if ((k % 2) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return (sum < 0) ? 64'd0 : 64'(sum);
	endfunction

	// Sigmoid at the midpoint of bin i of a table of the given depth, Q0.16.
	function automatic logic [PRED_W-1:0] sig_entry(input int depth, input int i);
		longint      s;
		logic [63:0] mag;
		logic [63:0] t;
		logic [63:0] n;
		logic [63:0] e;
		logic [63:0] em1;
		logic [63:0] den;
		logic [63:0] q;
		s   = 2 * longint'(i) - longint'(depth) + 1;
		mag = (s < 0) ? 64'(-s) : 64'(s);
		t   = udiv64(mag << 33, 64'(depth));
		n   = t >> 30;
		e   = exp_neg(t & (ONE_Q30 - 64'd1));
		em1 = exp_neg(ONE_Q30);
		for (int k = 0; k < 8; k++) begin
			if (64'(k) < n) begin
				e = (e * em1) >> 30;
			end
		end
		den = ONE_Q30 + e;
		if (s >= 0) begin
			q = udiv64((64'd1 << 46) + (den >> 1), den);
		end else begin
			q = udiv64((e << 16) + (den >> 1), den);
		end
		return q[PRED_W-1:0];
	endfunction

endpackage

### rtl/mlpf_front.sv
// ----------------------------------------------------------------------------
// mlpf_front: configuration registers and item classification
// Takes input transfers, drops items that have no effect, and pushes a
// command with the effective hidden count and the end-of-sample mark.
// ----------------------------------------------------------------------------
module mlpf_front #(
	parameter int MAX_INPUTS = mlpf_pkg::DEF_MAX_INPUTS,
	parameter int MAX_HIDDEN = mlpf_pkg::DEF_MAX_HIDDEN
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mlpf_pkg::CFG_AW-1:0]         cfg_index,
	input  logic [mlpf_pkg::CNT_W-1:0]          cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [mlpf_pkg::KIND_W-1:0]         kind,
	input  logic [mlpf_pkg::IDX_W-1:0]          index,
	input  logic signed [mlpf_pkg::VAL_W-1:0]   value,
	input  logic                                q_full,
	output logic                                q_push,
	output mlpf_pkg::cmd_t                      q_cmd
);
	import mlpf_pkg::*;

	localparam int HW_DEPTH = MAX_INPUTS * MAX_HIDDEN;

	logic [CNT_W-1:0] inputs_q;
	logic [CNT_W-1:0] hidden_q;
	logic [CNT_W-1:0] ni;
	logic [CNT_W-1:0] nh;
	logic             keep;

	// Configuration registers; every write is taken at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inputs_q <= INPUTS_RESET;
			hidden_q <= HIDDEN_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_INPUTS) begin
				inputs_q <= cfg_data;
			end
			if (cfg_index == REG_HIDDEN) begin
				hidden_q <= cfg_data;
			end
		end
	end

	// Effective counts: zero acts as one, large values stop at the maximum.
	always_comb begin
		if (inputs_q == '0) begin
			ni = CNT_W'(1);
		end else if (int'(inputs_q) > MAX_INPUTS) begin
			ni = CNT_W'(MAX_INPUTS);
		end else begin
			ni = inputs_q;
		end
		if (hidden_q == '0) begin
			nh = CNT_W'(1);
		end else if (int'(hidden_q) > MAX_HIDDEN) begin
			nh = CNT_W'(MAX_HIDDEN);
		end else begin
			nh = hidden_q;
		end
	end

	// Classify the item and decide whether it reaches the back part.
	always_comb begin
		case (kind)
			KIND_HW_WR:   keep = int'(index) < HW_DEPTH;
			KIND_OW_WR:   keep = int'(index) < MAX_HIDDEN;
			KIND_FEATURE: keep = index < IDX_W'(ni);
			default:      keep = 1'b0;
		endcase
	end

	always_comb begin
		q_cmd.op    = (kind == KIND_HW_WR) ? OP_HW_WR :
			(kind == KIND_OW_WR) ? OP_OW_WR : OP_FEATURE;
		q_cmd.last  = (index == IDX_W'(ni) - IDX_W'(1));
		q_cmd.nh    = nh;
		q_cmd.idx   = index;
		q_cmd.value = value;
	end

	assign item_stall = q_full;
	assign q_push     = item_valid && !item_stall && keep;

endmodule

### rtl/mlpf_queue.sv
// ----------------------------------------------------------------------------
// mlpf_queue: short command queue between the front and back parts
// A small first-in first-out buffer; full is a registered condition.
// ----------------------------------------------------------------------------
module mlpf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mlpf_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output mlpf_pkg::cmd_t head_cmd
);
	import mlpf_pkg::*;

	cmd_t                ent_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full       = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = ent_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

### rtl/mlpf_sigmoid.sv
// ----------------------------------------------------------------------------
// mlpf_sigmoid: three-stage sigmoid lookup
// Offsets the Q16.32 input, scales it to a table index, and reads the
// sigmoid table. A tag travels with each value.
// ----------------------------------------------------------------------------
module mlpf_sigmoid #(
	parameter int TABLE_DEPTH = mlpf_pkg::DEF_TABLE_DEPTH,
	parameter int TAG_W       = mlpf_pkg::CNT_W
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic signed [mlpf_pkg::ACC_W-1:0]  in_value,
	input  logic [TAG_W-1:0]                   in_tag,
	output logic                               out_valid,
	output logic [mlpf_pkg::PRED_W-1:0]        out_sig,
	output logic [TAG_W-1:0]                   out_tag,
	output logic                               busy
);
	import mlpf_pkg::*;

	localparam int TAB_AW = $clog2(TABLE_DEPTH);
	localparam int TD_W   = $clog2(TABLE_DEPTH + 1);
	localparam int PW     = 36 + TD_W;

	logic [PRED_W-1:0]       rom_w [TABLE_DEPTH];
	logic                    v_s1, v_s2, v_s3;
	logic [TAG_W-1:0]        tag_s1, tag_s2, tag_s3;
	logic signed [ACC_W:0]   u_s1;
	logic                    neg_s2;
	logic                    big_s2;
	logic [PW-1:0]           prod_s2;
	logic [TAB_AW-1:0]       addr;
	logic [PRED_W-1:0]       sig_s3;

	// Constant table, one entry per bin.
	for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_rom
		localparam logic [PRED_W-1:0] ENTRY = sig_entry(TABLE_DEPTH, gi);
		assign rom_w[gi] = ENTRY;
	end

	// Valid and tag pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage one shifts the range so that -8.0 maps to zero.
	// Stage two scales by the depth; the index is the top bits of the product.
	always_ff @(posedge clk) begin
		tag_s1  <= in_tag;
		u_s1    <= (ACC_W+1)'(in_value) + ((ACC_W+1)'(1) <<< 35);
		tag_s2  <= tag_s1;
		neg_s2  <= u_s1[ACC_W];
		big_s2  <= !u_s1[ACC_W] && (u_s1[ACC_W-1:36] != '0);
		prod_s2 <= PW'(u_s1[35:0]) * PW'(TABLE_DEPTH);
		tag_s3  <= tag_s2;
		sig_s3  <= rom_w[addr];
	end

	// Table address with saturation at both ends.
	always_comb begin
		if (neg_s2) begin
			addr = '0;
		end else if (big_s2) begin
			addr = TAB_AW'(TABLE_DEPTH - 1);
		end else begin
			addr = prod_s2[36 +: TAB_AW];
		end
	end

	assign out_valid = v_s3;
	assign out_sig   = sig_s3;
	assign out_tag   = tag_s3;
	assign busy      = v_s1 || v_s2 || v_s3;

endmodule

### rtl/mlpf_back.sv
// ----------------------------------------------------------------------------
// mlpf_back: weight stores, hidden accumulators and output evaluation
// Executes one command at a time: weight writes, a pipelined multiply and
// accumulate across the hidden units, and at the end of a sample the
// weighted sum of hidden activations and the final sigmoid.
// ----------------------------------------------------------------------------
module mlpf_back #(
	parameter int MAX_INPUTS  = mlpf_pkg::DEF_MAX_INPUTS,
	parameter int MAX_HIDDEN  = mlpf_pkg::DEF_MAX_HIDDEN,
	parameter int TABLE_DEPTH = mlpf_pkg::DEF_TABLE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  mlpf_pkg::cmd_t               cmd,
	output logic                         cmd_pop,
	output logic                         pred_valid,
	output logic [mlpf_pkg::PRED_W-1:0]  prediction,
	input  logic                         pred_stall
);
	import mlpf_pkg::*;

	localparam int HW_DEPTH = MAX_INPUTS * MAX_HIDDEN;
	localparam int HW_AW    = (HW_DEPTH > 1) ? $clog2(HW_DEPTH) : 1;
	localparam int HID_AW   = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
	localparam int J_W      = (HID_AW > CNT_W) ? HID_AW : CNT_W;
	localparam int TERM_W   = PRED_W + 1 + VAL_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_SUM   = 2'd2;
	localparam logic [1:0] ST_FINAL = 2'd3;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	logic [1:0]               state_q;
	logic [J_W-1:0]           j_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [VAL_W-1:0]  val_q;
	logic                     last_q;
	logic [CNT_W-1:0]         nh_q;
	logic                     issue;

	logic signed [VAL_W-1:0]  hw_mem [HW_DEPTH];
	logic signed [VAL_W-1:0]  ow_q [MAX_HIDDEN];
	logic signed [ACC_W-1:0]  acc_q [MAX_HIDDEN];
	logic [HW_AW-1:0]         hw_rd_addr;

	logic                     v_s1, v_s2;
	logic [J_W-1:0]           j_s1, j_s2;
	logic signed [VAL_W-1:0]  w_s1;
	logic signed [ACC_W-1:0]  p_s2;
	logic signed [ACC_W:0]    acc_sum;
	logic signed [ACC_W-1:0]  acc_sat;

	logic                     sg_in_valid;
	logic signed [ACC_W-1:0]  sg_in_value;
	logic                     sg_out_valid;
	logic [PRED_W-1:0]        sg_out_sig;
	logic [J_W-1:0]           sg_out_tag;
	logic                     sg_busy;

	logic                     tv_s1;
	logic signed [TERM_W-1:0] term_s1;
	logic signed [ACC_W-1:0]  z_q;
	logic                     sent_q;
	logic                     pred_valid_q;
	logic [PRED_W-1:0]        pred_q;
	logic                     done;

	// Commands are taken one at a time from the idle state.
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid;
	assign issue      = (j_q != J_W'(nh_q));
	assign hw_rd_addr = HW_AW'(int'(idx_q) * MAX_HIDDEN + int'(j_q));
	assign done       = (state_q == ST_FINAL) && sg_out_valid;

	// Hidden weight memory: written by commands, read by the accumulate loop.
	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.op == OP_HW_WR)) begin
			hw_mem[HW_AW'(cmd.idx)] <= cmd.value;
		end
		if ((state_q == ST_MAC) && issue) begin
			w_s1 <= hw_mem[hw_rd_addr];
		end
	end

	// Output weights and the multiply stages.
	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.op == OP_OW_WR)) begin
			ow_q[HID_AW'(cmd.idx)] <= cmd.value;
		end
		j_s1    <= j_q;
		j_s2    <= j_s1;
		p_s2    <= val_q * w_s1;
		term_s1 <= $signed({1'b0, sg_out_sig}) * ow_q[sg_out_tag[HID_AW-1:0]];
	end

	// Saturating accumulate into the signed 48-bit range.
	always_comb begin
		acc_sum = (ACC_W+1)'(acc_q[j_s2[HID_AW-1:0]]) + (ACC_W+1)'(p_s2);
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end
	end

	// Hidden accumulators, cleared when a sample completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int h = 0; h < MAX_HIDDEN; h++) begin
				acc_q[h] <= '0;
			end
		end else if (done) begin
			for (int h = 0; h < MAX_HIDDEN; h++) begin
				acc_q[h] <= '0;
			end
		end else if (v_s2) begin
			acc_q[j_s2[HID_AW-1:0]] <= acc_sat;
		end
	end

	// Sigmoid unit input: hidden sums during the sum phase, then the total.
	assign sg_in_valid = ((state_q == ST_SUM) && issue) ||
		((state_q == ST_FINAL) && !sent_q && !pred_valid_q);
	assign sg_in_value = (state_q == ST_FINAL) ? z_q : acc_q[j_q[HID_AW-1:0]];

	mlpf_sigmoid #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.TAG_W       (J_W)
	) u_sigmoid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sg_in_valid),
		.in_value  (sg_in_value),
		.in_tag    (j_q),
		.out_valid (sg_out_valid),
		.out_sig   (sg_out_sig),
		.out_tag   (sg_out_tag),
		.busy      (sg_busy)
	);

	// Current command fields.
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			idx_q  <= cmd.idx;
			val_q  <= cmd.value;
			last_q <= cmd.last;
			nh_q   <= cmd.nh;
		end
	end

	// Sequencer, loop counter and pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			tv_s1   <= 1'b0;
			z_q     <= '0;
			sent_q  <= 1'b0;
		end else begin
			v_s1  <= (state_q == ST_MAC) && issue;
			v_s2  <= v_s1;
			tv_s1 <= (state_q == ST_SUM) && sg_out_valid;
			if (tv_s1) begin
				z_q <= z_q + ACC_W'(term_s1);
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop && (cmd.op == OP_FEATURE)) begin
						state_q <= ST_MAC;
						j_q     <= '0;
					end
				end
				ST_MAC: begin
					if (issue) begin
						j_q <= j_q + J_W'(1);
					end else if (!v_s1 && !v_s2) begin
						j_q     <= '0;
						z_q     <= '0;
						state_q <= last_q ? ST_SUM : ST_IDLE;
					end
				end
				ST_SUM: begin
					if (issue) begin
						j_q <= j_q + J_W'(1);
					end else if (!sg_busy && !tv_s1) begin
						sent_q  <= 1'b0;
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (sg_in_valid) begin
						sent_q <= 1'b1;
					end
					if (sg_out_valid) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: holds the prediction until the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_valid_q <= 1'b0;
		end else if (done) begin
			pred_valid_q <= 1'b1;
		end else if (!pred_stall) begin
			pred_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			pred_q <= sg_out_sig;
		end
	end

	assign pred_valid = pred_valid_q;
	assign prediction = pred_q;

endmodule

### rtl/mlp_forward_inference.sv
// ----------------------------------------------------------------------------
// mlp_forward_inference: two-layer perceptron inference with sigmoid units
// Weight writes and features enter through one item channel; a prediction
// leaves on the result channel after the last feature of a sample arrives.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  item      item_valid/item_stall  kind, index, value
//  result    pred_valid/pred_stall  prediction
//  config    cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  A feature runs over nh hidden units, where nh is the effective hidden
//  count, through the single shared multiply and accumulate that visits one
//  hidden unit per cycle. A closing feature then passes the hidden sums
//  through the sigmoid table pipeline and adds the final lookup.
//  Reset clears the accumulators, the queue and the control state at once.
//  A two-entry queue lets items enter while the back part works, and a held
//  prediction does not stop the next sample until a new result is due.
// ----------------------------------------------------------------------------
module mlp_forward_inference #(
	parameter int MAX_INPUTS  = mlpf_pkg::DEF_MAX_INPUTS,
	parameter int MAX_HIDDEN  = mlpf_pkg::DEF_MAX_HIDDEN,
	parameter int TABLE_DEPTH = mlpf_pkg::DEF_TABLE_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mlpf_pkg::CFG_AW-1:0]        cfg_index,
	input  logic [mlpf_pkg::CNT_W-1:0]         cfg_data,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [mlpf_pkg::KIND_W-1:0]        kind,
	input  logic [mlpf_pkg::IDX_W-1:0]         index,
	input  logic signed [mlpf_pkg::VAL_W-1:0]  value,
	output logic                               pred_valid,
	input  logic                               pred_stall,
	output logic [mlpf_pkg::PRED_W-1:0]        prediction
);
	import mlpf_pkg::*;

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	logic q_valid;
	cmd_t q_head;

	// Front part: registers and classification.
	mlpf_front #(
		.MAX_INPUTS (MAX_INPUTS),
		.MAX_HIDDEN (MAX_HIDDEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.index      (index),
		.value      (value),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	// Command queue.
	mlpf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cmd   (q_head)
	);

	// Back part: execution and result register.
	mlpf_back #(
		.MAX_INPUTS  (MAX_INPUTS),
		.MAX_HIDDEN  (MAX_HIDDEN),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd        (q_head),
		.cmd_pop    (q_pop),
		.pred_valid (pred_valid),
		.prediction (prediction),
		.pred_stall (pred_stall)
	);

	// The back part never takes a command from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("command popped from an empty queue");

	// An empty queue never holds off the item channel.
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> !item_stall)
		else $error("item channel stalled with an empty queue");

	// A prediction never exceeds one in Q0.16.
	a_pred_range: assert property (@(posedge clk) disable iff (!arst_n)
		pred_valid |-> (prediction <= 17'd65536))
		else $error("prediction above one");

endmodule
